@@ hdl/gravity_pair_force_unit_assert.svh @@
// Assertion macros for the gravity pair force unit checker.
`ifndef GRAVITY_PAIR_FORCE_UNIT_ASSERT_SVH
`define GRAVITY_PAIR_FORCE_UNIT_ASSERT_SVH

// Check a consequence in the same cycle as its antecedent.
`define GPF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define GPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/gpf_pkg.sv @@
package gpf_pkg;

  localparam int FW   = 32;          // field width
  localparam int DW   = FW + 1;      // signed difference width
  localparam int SQW  = 2 * FW;      // one square
  localparam int RAWW = SQW + 1;     // sum of squares
  localparam int CW   = 64;          // clamp / distance register width
  localparam int PRW  = 96;          // G * ma * mb
  localparam int MW   = 88;          // magnitude quotient bits
  localparam int LW   = 49;          // length root bits
  localparam int SRW  = LW + 2;      // root remainder width
  localparam int VW   = 2 * LW;      // radicand width
  localparam int NW   = 120;         // magnitude times component
  localparam int SHF  = 8;           // Q.24 to Q.32 alignment
  localparam int QW   = 32;          // component quotient bits
  localparam int IW   = 2;           // register index width

  localparam logic [IW-1:0] CFG_GRAV = 2'd0;
  localparam logic [IW-1:0] CFG_MIN  = 2'd1;
  localparam logic [IW-1:0] CFG_MAX  = 2'd2;

  localparam logic [FW-1:0] GRAV_RST = 32'h0100_0000;
  localparam logic [CW-1:0] MIN_RST  = 64'h0000_0001_0000_0000;
  localparam logic [CW-1:0] MAX_RST  = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam logic [FW-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [FW-1:0] SAT_NEG = 32'h8000_0000;

  typedef struct packed {
    logic [CW-1:0] dsq;
    logic          big;
    logic [CW-1:0] rem0;
    logic [MW-1:0] quo0;
    logic [FW-1:0] ax;
    logic [FW-1:0] ay;
    logic          nx;
    logic          ny;
    logic          coin;
  } sq_side_t;

  typedef struct packed {
    logic [LW-1:0] len;
    logic          big;
    logic [FW-1:0] ax;
    logic [FW-1:0] ay;
    logic          nx;
    logic          ny;
    logic          coin;
  } mg_side_t;

  typedef struct packed {
    logic big;
    logic qbig;
    logic zero;
    logic neg;
    logic coin;
  } cx_side_t;

  typedef struct packed {
    logic qbig;
    logic zero;
    logic neg;
  } cy_side_t;

endpackage

@@ hdl/gravity_pair_force_unit.sv @@
// Gravity pair force unit: force on body a from body b in the plane.
// Channels: a request carries both bodies (in_valid / in_ready); the result
// carries force_x, force_y, saturated and coincident (out_valid / out_ready).
// Register writes (grav_constant, min_dist_sq, max_dist_sq by index) use
// cfg_valid / cfg_ready; cfg_ready is always high and writes belong to idle
// periods. Index 3 is ignored.
// Throughput: one request per cycle, sustained, as long as out_ready is high.
// Pipeline: 179 register stages, set by the cell chains: 49
// square-root digit cells for |d|, 88 restoring division cells for the
// magnitude and 32 division cells per force component.
// Stall: the whole chain advances on one enable; when a result waits and
// out_ready is low, every stage holds and in_ready drops in the same cycle.
// Reset: valid bits clear, registers return to G = 1.0, min = 1.0 and
// max = all ones; the block takes requests in the first cycle after reset.
module gravity_pair_force_unit
  import gpf_pkg::*;
#(
  parameter int POS_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [IW-1:0]        cfg_index,
  input  logic [CW-1:0]        cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [FW-1:0] first_pos_x,
  input  logic signed [FW-1:0] first_pos_y,
  input  logic [FW-1:0]        first_mass,
  input  logic signed [FW-1:0] second_pos_x,
  input  logic signed [FW-1:0] second_pos_y,
  input  logic [FW-1:0]        second_mass,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [FW-1:0] force_x,
  output logic signed [FW-1:0] force_y,
  output logic                 saturated,
  output logic                 coincident
);

  // Positions sign-extend from bit PW-1; anything past the field width acts as full width.
  localparam int PW = (POS_WIDTH < FW) ? POS_WIDTH : FW;
  localparam int SQS_W = $bits(sq_side_t);
  localparam int MGS_W = $bits(mg_side_t);
  localparam int CXS_W = $bits(cx_side_t);
  localparam int CYS_W = $bits(cy_side_t);
  localparam int P2W   = MW - 2 * FW + FW;   // top magnitude slice times component
  localparam int HIW   = NW + SHF - QW;      // numerator bits above the quotient

  function automatic logic signed [DW-1:0] sext(input logic [FW-1:0] v);
    return {{(DW-PW){v[PW-1]}}, v[PW-1:0]};
  endfunction

  // Registers
  logic [FW-1:0] grav_constant;
  logic [CW-1:0] min_dist_sq;
  logic [CW-1:0] max_dist_sq;

  logic en;

  assign cfg_ready = 1'b1;
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      grav_constant <= GRAV_RST;
      min_dist_sq   <= MIN_RST;
      max_dist_sq   <= MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GRAV: grav_constant <= cfg_data[FW-1:0];
        CFG_MIN:  min_dist_sq   <= cfg_data;
        CFG_MAX:  max_dist_sq   <= cfg_data;
        default:  ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Front stages: differences, squares, mass product, clamp.
  // ---------------------------------------------------------------------
  logic                 s1_v, s2_v, s3_v, s4_v, s5_v, s6_v;
  logic signed [DW-1:0] s1_dx, s1_dy;
  logic [2*FW-1:0]      s1_gm;
  logic [FW-1:0]        s1_mb;

  logic signed [2*DW-1:0] sqx_w, sqy_w;
  logic [DW-1:0]          ax_w, ay_w;
  logic [SQW-1:0]         s2_sqx, s2_sqy;
  logic [FW-1:0]          s2_ax, s2_ay;
  logic                   s2_nx, s2_ny;
  logic [2*FW-1:0]        s2_pl, s2_ph;

  logic [RAWW-1:0] s3_raw;
  logic [PRW-1:0]  s3_prod;
  logic [FW-1:0]   s3_ax, s3_ay;
  logic            s3_nx, s3_ny, s3_coin;

  logic [CW-1:0]   d1_w;
  logic [CW-1:0]   s4_dsq;
  logic [RAWW-1:0] s4_raw;
  logic [PRW-1:0]  s4_prod;
  logic [FW-1:0]   s4_ax, s4_ay;
  logic            s4_nx, s4_ny, s4_coin;

  logic [CW-1:0]   s5_dsq;
  logic [RAWW-1:0] s5_raw;
  logic [PRW-1:0]  s5_prod;
  logic [FW-1:0]   s5_ax, s5_ay;
  logic            s5_nx, s5_ny, s5_coin;

  logic            big_w;
  sq_side_t        s6_side;
  logic [RAWW-1:0] s6_raw;

  always_comb begin
    sqx_w = s1_dx * s1_dx;
    sqy_w = s1_dy * s1_dy;
    ax_w  = s1_dx[DW-1] ? DW'(-s1_dx) : DW'(s1_dx);
    ay_w  = s1_dy[DW-1] ? DW'(-s1_dy) : DW'(s1_dy);
    // saturate the sum of squares to 64 bits, raise to min, then lower to max
    d1_w  = s3_raw[RAWW-1] ? {CW{1'b1}} : s3_raw[CW-1:0];
    d1_w  = (d1_w < min_dist_sq) ? min_dist_sq : d1_w;
    // magnitude overflows past 88 bits exactly when the top byte reaches the divisor
    big_w = (CW'(s5_prod[PRW-1:MW]) >= s5_dsq);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
      s6_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      s5_v <= s4_v;
      s6_v <= s5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx   <= sext(second_pos_x) - sext(first_pos_x);
      s1_dy   <= sext(second_pos_y) - sext(first_pos_y);
      s1_gm   <= grav_constant * first_mass;
      s1_mb   <= second_mass;

      s2_sqx  <= sqx_w[SQW-1:0];
      s2_sqy  <= sqy_w[SQW-1:0];
      s2_ax   <= ax_w[FW-1:0];
      s2_ay   <= ay_w[FW-1:0];
      s2_nx   <= s1_dx[DW-1];
      s2_ny   <= s1_dy[DW-1];
      s2_pl   <= s1_gm[FW-1:0] * s1_mb;
      s2_ph   <= s1_gm[2*FW-1:FW] * s1_mb;

      s3_raw  <= RAWW'(s2_sqx) + RAWW'(s2_sqy);
      s3_prod <= {s2_ph, {FW{1'b0}}} + PRW'(s2_pl);
      s3_ax   <= s2_ax;
      s3_ay   <= s2_ay;
      s3_nx   <= s2_nx;
      s3_ny   <= s2_ny;
      s3_coin <= (s2_ax == '0) && (s2_ay == '0);

      s4_dsq  <= d1_w;
      s4_raw  <= s3_raw;
      s4_prod <= s3_prod;
      s4_ax   <= s3_ax;
      s4_ay   <= s3_ay;
      s4_nx   <= s3_nx;
      s4_ny   <= s3_ny;
      s4_coin <= s3_coin;

      s5_dsq  <= (s4_dsq > max_dist_sq) ? max_dist_sq : s4_dsq;
      s5_raw  <= s4_raw;
      s5_prod <= s4_prod;
      s5_ax   <= s4_ax;
      s5_ay   <= s4_ay;
      s5_nx   <= s4_nx;
      s5_ny   <= s4_ny;
      s5_coin <= s4_coin;

      s6_side.dsq  <= s5_dsq;
      s6_side.big  <= big_w;
      s6_side.rem0 <= big_w ? '0 : CW'(s5_prod[PRW-1:MW]);
      s6_side.quo0 <= s5_prod[MW-1:0];
      s6_side.ax   <= s5_ax;
      s6_side.ay   <= s5_ay;
      s6_side.nx   <= s5_nx;
      s6_side.ny   <= s5_ny;
      s6_side.coin <= s5_coin;
      s6_raw       <= s5_raw;
    end
  end

  // ---------------------------------------------------------------------
  // Length chain: |d| in Q.32 as floor(sqrt(raw * 2^32)).
  // ---------------------------------------------------------------------
  logic             sq_v    [0:LW];
  logic [SRW-1:0]   sq_rem  [0:LW];
  logic [LW-1:0]    sq_root [0:LW];
  logic [VW-1:0]    sq_val  [0:LW];
  logic [SQS_W-1:0] sq_side [0:LW];

  assign sq_v[0]    = s6_v;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_val[0]  = VW'({s6_raw, {FW{1'b0}}});
  assign sq_side[0] = s6_side;

  for (genvar i = 0; i < LW; i++) begin : g_sqrt
    gpf_sqrt_cell #(
      .RW    (SRW),
      .ROOTW (LW),
      .VW    (VW),
      .SW    (SQS_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .valid_in  (sq_v[i]),
      .rem_in    (sq_rem[i]),
      .root_in   (sq_root[i]),
      .val_in    (sq_val[i]),
      .side_in   (sq_side[i]),
      .valid_out (sq_v[i+1]),
      .rem_out   (sq_rem[i+1]),
      .root_out  (sq_root[i+1]),
      .val_out   (sq_val[i+1]),
      .side_out  (sq_side[i+1])
    );
  end

  // ---------------------------------------------------------------------
  // Magnitude chain: floor(G * ma * mb / clamped squared distance), 88 bits.
  // ---------------------------------------------------------------------
  sq_side_t sq_last;
  mg_side_t mg_first;

  always_comb begin
    sq_last       = sq_side_t'(sq_side[LW]);
    mg_first.len  = sq_root[LW];
    mg_first.big  = sq_last.big;
    mg_first.ax   = sq_last.ax;
    mg_first.ay   = sq_last.ay;
    mg_first.nx   = sq_last.nx;
    mg_first.ny   = sq_last.ny;
    mg_first.coin = sq_last.coin;
  end

  logic             mg_v    [0:MW];
  logic [CW-1:0]    mg_rem  [0:MW];
  logic [MW-1:0]    mg_quo  [0:MW];
  logic [CW-1:0]    mg_div  [0:MW];
  logic [MGS_W-1:0] mg_side [0:MW];

  assign mg_v[0]    = sq_v[LW];
  assign mg_rem[0]  = sq_last.rem0;
  assign mg_quo[0]  = sq_last.quo0;
  assign mg_div[0]  = sq_last.dsq;
  assign mg_side[0] = mg_first;

  for (genvar i = 0; i < MW; i++) begin : g_mag
    gpf_div_cell #(
      .RW (CW),
      .QW (MW),
      .SW (MGS_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .valid_in  (mg_v[i]),
      .rem_in    (mg_rem[i]),
      .quo_in    (mg_quo[i]),
      .div_in    (mg_div[i]),
      .side_in   (mg_side[i]),
      .valid_out (mg_v[i+1]),
      .rem_out   (mg_rem[i+1]),
      .quo_out   (mg_quo[i+1]),
      .div_out   (mg_div[i+1]),
      .side_out  (mg_side[i+1])
    );
  end

  // ---------------------------------------------------------------------
  // Numerators: magnitude times each component, in three slices.
  // ---------------------------------------------------------------------
  mg_side_t mg_last;
  logic [MW-1:0] mag;

  assign mg_last = mg_side_t'(mg_side[MW]);
  assign mag     = mg_quo[MW];

  logic            m1_v, m2_v, m3_v;
  logic [2*FW-1:0] m1_px0, m1_px1, m1_py0, m1_py1;
  logic [P2W-1:0]  m1_px2, m1_py2;
  logic [LW-1:0]   m1_len, m2_len, m3_len;
  logic            m1_big, m2_big, m3_big;
  logic            m1_zx, m1_zy, m2_zx, m2_zy, m3_zx, m3_zy;
  logic            m1_nx, m1_ny, m2_nx, m2_ny, m3_nx, m3_ny;
  logic            m1_coin, m2_coin, m3_coin;
  logic [NW-1:0]   m2_nx_val, m2_ny_val;

  logic [NW+SHF-1:0] ext_x, ext_y;
  logic [HIW-1:0]    hi_x, hi_y;
  logic              qbig_x, qbig_y;
  logic [LW-1:0]     m3_remx, m3_remy;
  logic [QW-1:0]     m3_quox, m3_quoy;
  logic              m3_qbx, m3_qby;

  always_comb begin
    ext_x  = {m2_nx_val, {SHF{1'b0}}};
    ext_y  = {m2_ny_val, {SHF{1'b0}}};
    hi_x   = ext_x[NW+SHF-1:QW];
    hi_y   = ext_y[NW+SHF-1:QW];
    // quotient reaches 2^32 exactly when the upper numerator reaches the length
    qbig_x = (hi_x >= HIW'(m2_len));
    qbig_y = (hi_y >= HIW'(m2_len));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v <= 1'b0;
      m2_v <= 1'b0;
      m3_v <= 1'b0;
    end else if (en) begin
      m1_v <= mg_v[MW];
      m2_v <= m1_v;
      m3_v <= m2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_px0  <= mag[FW-1:0] * mg_last.ax;
      m1_px1  <= mag[2*FW-1:FW] * mg_last.ax;
      m1_px2  <= mag[MW-1:2*FW] * mg_last.ax;
      m1_py0  <= mag[FW-1:0] * mg_last.ay;
      m1_py1  <= mag[2*FW-1:FW] * mg_last.ay;
      m1_py2  <= mag[MW-1:2*FW] * mg_last.ay;
      m1_len  <= mg_last.len;
      m1_big  <= mg_last.big;
      m1_zx   <= (mg_last.ax == '0);
      m1_zy   <= (mg_last.ay == '0);
      m1_nx   <= mg_last.nx;
      m1_ny   <= mg_last.ny;
      m1_coin <= mg_last.coin;

      m2_nx_val <= NW'({m1_px2, {(2*FW){1'b0}}}) + NW'({m1_px1, {FW{1'b0}}})
                   + NW'(m1_px0);
      m2_ny_val <= NW'({m1_py2, {(2*FW){1'b0}}}) + NW'({m1_py1, {FW{1'b0}}})
                   + NW'(m1_py0);
      m2_len  <= m1_len;
      m2_big  <= m1_big;
      m2_zx   <= m1_zx;
      m2_zy   <= m1_zy;
      m2_nx   <= m1_nx;
      m2_ny   <= m1_ny;
      m2_coin <= m1_coin;

      m3_remx <= qbig_x ? '0 : hi_x[LW-1:0];
      m3_remy <= qbig_y ? '0 : hi_y[LW-1:0];
      m3_quox <= ext_x[QW-1:0];
      m3_quoy <= ext_y[QW-1:0];
      m3_qbx  <= qbig_x;
      m3_qby  <= qbig_y;
      m3_len  <= m2_len;
      m3_big  <= m2_big;
      m3_zx   <= m2_zx;
      m3_zy   <= m2_zy;
      m3_nx   <= m2_nx;
      m3_ny   <= m2_ny;
      m3_coin <= m2_coin;
    end
  end

  // ---------------------------------------------------------------------
  // Component chains: numerator / length, 32 quotient bits per lane.
  // ---------------------------------------------------------------------
  cx_side_t cx_first;
  cy_side_t cy_first;

  always_comb begin
    cx_first.big  = m3_big;
    cx_first.qbig = m3_qbx;
    cx_first.zero = m3_zx;
    cx_first.neg  = m3_nx;
    cx_first.coin = m3_coin;
    cy_first.qbig = m3_qby;
    cy_first.zero = m3_zy;
    cy_first.neg  = m3_ny;
  end

  logic             cx_v    [0:QW];
  logic [LW-1:0]    cx_rem  [0:QW];
  logic [QW-1:0]    cx_quo  [0:QW];
  logic [LW-1:0]    cx_div  [0:QW];
  logic [CXS_W-1:0] cx_side [0:QW];
  logic             cy_v    [0:QW];
  logic [LW-1:0]    cy_rem  [0:QW];
  logic [QW-1:0]    cy_quo  [0:QW];
  logic [LW-1:0]    cy_div  [0:QW];
  logic [CYS_W-1:0] cy_side [0:QW];

  assign cx_v[0]    = m3_v;
  assign cx_rem[0]  = m3_remx;
  assign cx_quo[0]  = m3_quox;
  assign cx_div[0]  = m3_len;
  assign cx_side[0] = cx_first;
  assign cy_v[0]    = m3_v;
  assign cy_rem[0]  = m3_remy;
  assign cy_quo[0]  = m3_quoy;
  assign cy_div[0]  = m3_len;
  assign cy_side[0] = cy_first;

  for (genvar i = 0; i < QW; i++) begin : g_comp
    gpf_div_cell #(
      .RW (LW),
      .QW (QW),
      .SW (CXS_W)
    ) u_cell_x (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .valid_in  (cx_v[i]),
      .rem_in    (cx_rem[i]),
      .quo_in    (cx_quo[i]),
      .div_in    (cx_div[i]),
      .side_in   (cx_side[i]),
      .valid_out (cx_v[i+1]),
      .rem_out   (cx_rem[i+1]),
      .quo_out   (cx_quo[i+1]),
      .div_out   (cx_div[i+1]),
      .side_out  (cx_side[i+1])
    );

    gpf_div_cell #(
      .RW (LW),
      .QW (QW),
      .SW (CYS_W)
    ) u_cell_y (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .valid_in  (cy_v[i]),
      .rem_in    (cy_rem[i]),
      .quo_in    (cy_quo[i]),
      .div_in    (cy_div[i]),
      .side_in   (cy_side[i]),
      .valid_out (cy_v[i+1]),
      .rem_out   (cy_rem[i+1]),
      .quo_out   (cy_quo[i+1]),
      .div_out   (cy_div[i+1]),
      .side_out  (cy_side[i+1])
    );
  end

  // ---------------------------------------------------------------------
  // Output register: sign, saturation, flags.
  // ---------------------------------------------------------------------
  cx_side_t      cx_last;
  cy_side_t      cy_last;
  logic [QW-1:0] qx, qy;
  logic          ovf_x, ovf_y;
  logic [FW-1:0] fx_next, fy_next;
  logic          satx_next, saty_next;

  always_comb begin
    cx_last = cx_side_t'(cx_side[QW]);
    cy_last = cy_side_t'(cy_side[QW]);
    qx      = cx_quo[QW];
    qy      = cy_quo[QW];
    // a huge magnitude clips every nonzero component
    ovf_x = cx_last.big || cx_last.qbig ||
            (cx_last.neg ? (qx > SAT_NEG) : (qx > SAT_POS));
    ovf_y = cx_last.big || cy_last.qbig ||
            (cy_last.neg ? (qy > SAT_NEG) : (qy > SAT_POS));
    satx_next = !cx_last.zero && ovf_x;
    saty_next = !cy_last.zero && ovf_y;
    if (cx_last.zero) begin
      fx_next = '0;
    end else if (ovf_x) begin
      fx_next = cx_last.neg ? SAT_NEG : SAT_POS;
    end else begin
      fx_next = cx_last.neg ? (~qx + 1'b1) : qx;
    end
    if (cy_last.zero) begin
      fy_next = '0;
    end else if (ovf_y) begin
      fy_next = cy_last.neg ? SAT_NEG : SAT_POS;
    end else begin
      fy_next = cy_last.neg ? (~qy + 1'b1) : qy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= cx_v[QW] && cy_v[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      force_x    <= fx_next;
      force_y    <= fy_next;
      saturated  <= satx_next || saty_next;
      coincident <= cx_last.coin;
    end
  end

endmodule

@@ hdl/gpf_div_cell.sv @@
// One restoring division step: shift in a numerator bit, subtract if it fits.
module gpf_div_cell #(
  parameter int RW = 64,
  parameter int QW = 88,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          valid_in,
  input  logic [RW-1:0] rem_in,
  input  logic [QW-1:0] quo_in,
  input  logic [RW-1:0] div_in,
  input  logic [SW-1:0] side_in,
  output logic          valid_out,
  output logic [RW-1:0] rem_out,
  output logic [QW-1:0] quo_out,
  output logic [RW-1:0] div_out,
  output logic [SW-1:0] side_out
);

  logic [RW:0]   trial;
  logic [RW:0]   diff;
  logic          take;
  logic [RW-1:0] rem_next;
  logic [QW-1:0] quo_next;

  always_comb begin
    trial    = {rem_in, quo_in[QW-1]};
    diff     = trial - {1'b0, div_in};
    take     = (trial >= {1'b0, div_in});
    rem_next = take ? diff[RW-1:0] : trial[RW-1:0];
    quo_next = {quo_in[QW-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= rem_next;
      quo_out  <= quo_next;
      div_out  <= div_in;
      side_out <= side_in;
    end
  end

endmodule

@@ hdl/gpf_sqrt_cell.sv @@
// One digit of a bit-serial square root: bring down two radicand bits, try root*4+1.
module gpf_sqrt_cell #(
  parameter int RW    = 51,
  parameter int ROOTW = 49,
  parameter int VW    = 98,
  parameter int SW    = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             valid_in,
  input  logic [RW-1:0]    rem_in,
  input  logic [ROOTW-1:0] root_in,
  input  logic [VW-1:0]    val_in,
  input  logic [SW-1:0]    side_in,
  output logic             valid_out,
  output logic [RW-1:0]    rem_out,
  output logic [ROOTW-1:0] root_out,
  output logic [VW-1:0]    val_out,
  output logic [SW-1:0]    side_out
);

  logic [RW+1:0]    cur;
  logic [RW+1:0]    trial;
  logic [RW+1:0]    diff;
  logic             take;
  logic [RW-1:0]    rem_next;
  logic [ROOTW-1:0] root_next;

  always_comb begin
    cur       = {rem_in, val_in[VW-1 -: 2]};
    trial     = {{(RW-ROOTW){1'b0}}, root_in, 2'b01};
    diff      = cur - trial;
    take      = (cur >= trial);
    rem_next  = take ? diff[RW-1:0] : cur[RW-1:0];
    root_next = {root_in[ROOTW-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= rem_next;
      root_out <= root_next;
      val_out  <= {val_in[VW-3:0], 2'b00};
      side_out <= side_in;
    end
  end

endmodule

@@ hdl/gpf_checker.sv @@
`include "gravity_pair_force_unit_assert.svh"

module gpf_checker
  import gpf_pkg::*;
(
  input logic          clk,
  input logic          rst,
  input logic          out_valid,
  input logic          out_ready,
  input logic [FW-1:0] force_x,
  input logic [FW-1:0] force_y,
  input logic          saturated,
  input logic          coincident
);

  // hold a stalled result
  `GPF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `GPF_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(force_x) && $stable(force_y) && $stable(saturated) && $stable(coincident), "stalled result changed")

  // coincident bodies give no force and no clipping
  `GPF_ASSERT_NOW(a_coin_zero, out_valid && coincident, force_x == '0 && force_y == '0 && !saturated, "coincident result not zero")

  // a clipped result shows a rail value in some component
  `GPF_ASSERT_NOW(a_sat_rail, out_valid && saturated, force_x == SAT_POS || force_x == SAT_NEG || force_y == SAT_POS || force_y == SAT_NEG, "saturated without rail value")

endmodule

bind gravity_pair_force_unit gpf_checker u_gpf_checker (.*);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

// Pairwise gravity force unit: directed table, then randomised body pairs over
// several register settings, checked against a bit-exact predictor.
module tb_top;
  import gpf_pkg::*;

  localparam logic [IW-1:0] CFG_SPARE = 2'd3;  // unused index, must be ignored
  localparam int            DRAIN     = 200;   // longer than the pipeline latency

  typedef struct {
    logic signed [FW-1:0] ax, ay;
    logic [FW-1:0]        ma;
    logic signed [FW-1:0] bx, by;
    logic [FW-1:0]        mb;
  } pair_t;

  typedef struct {
    logic [FW-1:0] fx, fy;
    logic          sat, coin;
  } force_t;

  typedef struct {
    pair_t  p;
    bit     typed;   // expectation read off by hand
    force_t f;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [IW-1:0]        cfg_index = CFG_GRAV;
  logic [CW-1:0]        cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [FW-1:0] first_pos_x = '0, first_pos_y = '0;
  logic [FW-1:0]        first_mass = '0;
  logic signed [FW-1:0] second_pos_x = '0, second_pos_y = '0;
  logic [FW-1:0]        second_mass = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [FW-1:0] force_x, force_y;
  logic                 saturated, coincident;

  // Mirror of the register file
  logic [FW-1:0] grav_reg;
  logic [CW-1:0] min_reg, max_reg;

  force_t pending_forces[$];
  int     mismatches = 0;
  int     idle_pct = 37;

  always #10 clk = ~clk;

  gravity_pair_force_unit u_dut (.*);

  // One force component: magnitude along the unit vector, truncated toward
  // zero, clipped to Q16.16 with the flag raised on a clip.
  function automatic logic [FW-1:0] force_component(logic [127:0] mag, logic big,
      logic [127:0] ad, logic neg, logic [127:0] len, inout logic sat);
    logic [127:0] quo, limit;
    if (ad == 0) return '0;
    limit = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (!big) begin
      quo = ((mag * ad) << SHF) / len;
      if (quo <= limit) return neg ? -quo[FW-1:0] : quo[FW-1:0];
    end
    sat = 1'b1;
    return neg ? SAT_NEG : SAT_POS;
  endfunction

  function automatic force_t predict_force(pair_t p);
    logic signed [FW:0] dx, dy;
    logic [127:0] ax, ay, raw, dsq, prod, mag, root, trial;
    logic big, sat;
    force_t r;
    dx = {p.bx[FW-1], p.bx} - {p.ax[FW-1], p.ax};
    dy = {p.by[FW-1], p.by} - {p.ay[FW-1], p.ay};
    r = '{fx: '0, fy: '0, sat: 1'b0, coin: 1'b0};
    if (dx == 0 && dy == 0) begin
      r.coin = 1'b1;
      return r;
    end
    ax = dx < 0 ? 128'(-dx) : 128'(dx);
    ay = dy < 0 ? 128'(-dy) : 128'(dy);
    raw = ax * ax + ay * ay;
    dsq = raw[127:64] != 0 ? 128'(MAX_RST) : raw;
    if (dsq < 128'(min_reg)) dsq = 128'(min_reg);
    if (dsq > 128'(max_reg)) dsq = 128'(max_reg);
    prod = 128'(grav_reg) * 128'(p.ma) * 128'(p.mb);
    mag = '0;
    if (dsq == 0) begin
      big = 1'b1;
    end else begin
      mag = prod / dsq;
      big = mag >= (128'd1 << MW);
    end
    // exact length in Q.32 from the unclamped distance
    root = '0;
    for (int i = LW - 1; i >= 0; i--) begin
      trial = root | (128'd1 << i);
      if (trial * trial <= (raw << 32)) root = trial;
    end
    sat = 1'b0;
    r.fx = force_component(mag, big, ax, dx < 0, root, sat);
    r.fy = force_component(mag, big, ay, dy < 0, root, sat);
    r.sat = sat;
    return r;
  endfunction

  // Hold off for a random gap, then present one request until accepted.
  task automatic send_pair(pair_t p, bit typed, force_t f);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    first_pos_x  <= p.ax;
    first_pos_y  <= p.ay;
    first_mass   <= p.ma;
    second_pos_x <= p.bx;
    second_pos_y <= p.by;
    second_mass  <= p.mb;
    do @(posedge clk); while (!in_ready);
    pending_forces.push_back(typed ? f : predict_force(p));
  endtask

  // Present one register write until accepted; the caller drops cfg_valid
  // after the last write of a group.
  task automatic write_reg(logic [IW-1:0] idx, logic [CW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_GRAV: grav_reg = val[FW-1:0];
      CFG_MIN:  min_reg = val;
      CFG_MAX:  max_reg = val;
      default: ;
    endcase
  endtask

  // Drop valid and let the pipe drain before touching registers.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_forces.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // Mostly near pairs with moderate masses so the force lands in range; some
  // share an x coordinate, and the rest span every bit of every field.
  function automatic pair_t random_pair();
    pair_t p;
    int mode;
    mode = $urandom_range(9);
    p.ax = $urandom;
    p.ay = $urandom;
    p.ma = $urandom;
    p.mb = $urandom;
    if (mode < 6) begin
      p.bx = p.ax + $signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000;
      p.by = p.ay + $signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000;
      p.ma = $urandom_range(32'h0008_0000);
      p.mb = $urandom_range(32'h0008_0000);
    end else if (mode == 6) begin
      p.bx = p.ax;
      p.by = p.ay + $signed($urandom_range(32'h0000_1000)) - 32'sh0000_0800;
    end else begin
      p.bx = $urandom;
      p.by = $urandom;
    end
    return p;
  endfunction

  // Result checker: compare every accepted result against the oldest prediction
  always @(posedge clk) begin
    force_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_forces.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result fx=%h fy=%h", force_x, force_y);
      end else begin
        want = pending_forces.pop_front();
        if (force_x !== want.fx || force_y !== want.fy ||
            saturated !== want.sat || coincident !== want.coin) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp fx=%h fy=%h sat=%b coin=%b, got fx=%h fy=%h sat=%b coin=%b",
                     want.fx, want.fy, want.sat, want.coin,
                     force_x, force_y, saturated, coincident);
        end
      end
    end
  end

  // Sink stalls at the same rate as the source, none in the quiet stretch
  always @(posedge clk) out_ready <= ($urandom_range(99) >= idle_pct);

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    row_t   rows[$];
    force_t none;
    force_t coin_f;
    pair_t  p;
    none   = '{fx: '0, fy: '0, sat: 1'b0, coin: 1'b0};
    coin_f = '{fx: '0, fy: '0, sat: 1'b0, coin: 1'b1};
    grav_reg = GRAV_RST;
    min_reg  = MIN_RST;
    max_reg  = MAX_RST;

    // Coincident bodies, zero and full masses
    rows.push_back('{'{'0, '0, '0, '0, '0, '0}, 1, coin_f});
    rows.push_back('{'{32'sh8000_0000, 32'sh8000_0000, '1, 32'sh8000_0000, 32'sh8000_0000, '1},
                     1, coin_f});
    // One ulp apart with full masses: far beyond range on the nonzero axis
    rows.push_back('{'{'0, '0, '1, 32'sd1, '0, '1}, 1,
                     '{fx: SAT_POS, fy: '0, sat: 1'b1, coin: 1'b0}});
    rows.push_back('{'{'0, '0, '1, -32'sd1, '0, '1}, 1,
                     '{fx: SAT_NEG, fy: '0, sat: 1'b1, coin: 1'b0}});
    rows.push_back('{'{'0, '0, '1, '0, 32'sd1, '1}, 1,
                     '{fx: '0, fy: SAT_POS, sat: 1'b1, coin: 1'b0}});
    // Unit masses one unit apart give a force of exactly one
    rows.push_back('{'{'0, '0, 32'h0001_0000, 32'sh0001_0000, '0, 32'h0001_0000}, 1,
                     '{fx: 32'h0001_0000, fy: '0, sat: 1'b0, coin: 1'b0}});
    rows.push_back('{'{'0, '0, 32'h0001_0000, -32'sh0001_0000, '0, 32'h0001_0000}, 1,
                     '{fx: 32'hFFFF_0000, fy: '0, sat: 1'b0, coin: 1'b0}});
    // Opposite corners, widest differences
    rows.push_back('{'{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, '0, 32'sh8000_0000, 32'sh8000_0000, '0},
                     0, none});
    rows.push_back('{'{32'sh8000_0000, 32'sh8000_0000, '1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, '1},
                     0, none});
    rows.push_back('{'{32'sh8000_0000, 32'sh7FFF_FFFF, 32'h0001_0000,
                       32'sh7FFF_FFFF, 32'sh8000_0000, 32'h0001_0000}, 0, none});
    rows.push_back('{'{'0, '0, 32'h0001_0000, 32'sh0003_0000, 32'sh0004_0000, 32'h0002_0000},
                     0, none});
    rows.push_back('{'{32'sh0001_0000, '0, '0, '0, 32'sh0001_0000, '1}, 0, none});
    rows.push_back('{'{'0, 32'sh0000_8000, '1, 32'sh0000_0100, '0, 32'h0000_0001}, 0, none});

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send_pair(rows[i].p, rows[i].typed, rows[i].f);

    for (int phase = 0; phase < 5; phase++) begin
      drain();
      case (phase)
        0: begin  // largest G, no lower clamp; spare index must change nothing
          write_reg(CFG_GRAV, 64'hFFFF_FFFF);
          write_reg(CFG_MIN, '0);
          write_reg(CFG_MAX, MAX_RST);
          write_reg(CFG_SPARE, '1);
        end
        1: begin  // crossed limits, upper clamp of zero wins
          write_reg(CFG_GRAV, '0);
          write_reg(CFG_MIN, 64'h0000_0001_0000_0000);
          write_reg(CFG_MAX, '0);
        end
        2: begin  // narrow clamp window, random G
          write_reg(CFG_GRAV, {32'h0, $urandom});
          write_reg(CFG_MIN, 64'h0000_0100_0000_0000);
          write_reg(CFG_MAX, 64'h0004_0000_0000_0000);
        end
        3: begin  // minimum clamp at its top
          write_reg(CFG_GRAV, GRAV_RST);
          write_reg(CFG_MIN, '1);
          write_reg(CFG_MAX, MAX_RST);
        end
        default: begin
          write_reg(CFG_GRAV, {32'h0, 32'h0000_4000});
          write_reg(CFG_MIN, '0);
          write_reg(CFG_MAX, {$urandom, $urandom});
        end
      endcase
      cfg_valid <= 1'b0;
      for (int n = 0; n < 220; n++) begin
        // hold a stretch of back-to-back traffic in one phase
        idle_pct = (phase == 2 && n < 120) ? 0 : 37;
        p = random_pair();
        send_pair(p, 0, none);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_forces.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
